// ----- sv/price_level_order_book_macros.svh -----
// Assertion macros for the price level order book
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
// assert that a condition implies a consequence on the same edge
`define PLOB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// assert that a condition implies a consequence on the next edge
`define PLOB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- sv/plob_pkg.sv -----
// ---------------------------------------------------------------------------
// plob_pkg
// Types, constants and codes shared by the price level order book.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package plob_pkg;
    localparam int ORDER_SLOTS_DEF = 1024;
    localparam int LEVELS_DEF      = 64;
    localparam int PRICE_W = 32;
    localparam int TOTAL_W = 34;
    localparam int COUNT_W = 11;
    localparam int QTY_W   = 24;
    localparam int ID_W    = 10;
    localparam int IDX_W   = 6;

    typedef enum logic [2:0] {
        OP_NEW    = 3'd0,
        OP_CHANGE = 3'd1,
        OP_REPL   = 3'd2,
        OP_DEL    = 3'd3,
        OP_QPRICE = 3'd4,
        OP_QSIZE  = 3'd5,
        OP_QNUM   = 3'd6,
        OP_QCOUNT = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_DUP     = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Level cell contents
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } t_level;

    // Command broadcast to every cell of one side
    typedef enum logic [2:0] {
        CC_NONE   = 3'd0,
        CC_INSERT = 3'd1,
        CC_ADD    = 3'd2,
        CC_SUB    = 3'd3,
        CC_REMOVE = 3'd4
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [PRICE_W-1:0] price;
        logic [TOTAL_W-1:0] delta;
        logic               dec;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_FETCH  = 3'd1,
        S_EXEC   = 3'd2,
        S_ADD    = 3'd3,
        S_OUT    = 3'd4,
        S_RM     = 3'd5,
        S_CLEAR  = 3'd6
    } t_state;
endpackage

// ----- sv/plob_cell.sv -----
// ---------------------------------------------------------------------------
// plob_cell
// One price level of a side: matches its price and shifts with neighbours.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module plob_cell (
    input  wire                  i_clk,
    input  wire                  i_sell,
    input  wire                  i_here_used,
    input  plob_pkg::t_cell_ctl  i_ctl,
    input  plob_pkg::t_level     i_left,
    input  wire                  i_left_better,
    input  plob_pkg::t_level     i_right,
    output plob_pkg::t_level     o_level,
    output logic                 o_match,
    output logic                 o_better
);
    import plob_pkg::*;

    t_level r_lv;
    t_level n_lv;

    // compare own price with the command price
    always_comb begin
        o_match  = i_here_used && (r_lv.price == i_ctl.price);
        o_better = i_here_used && (i_sell ? (r_lv.price < i_ctl.price)
                                          : (r_lv.price > i_ctl.price));
    end

    // next contents by command
    always_comb begin
        n_lv = r_lv;
        case (i_ctl.cmd)
            CC_INSERT: begin
                if (!o_better) begin
                    if (i_left_better) begin
                        n_lv.price = i_ctl.price;
                        n_lv.total = '0;
                        n_lv.count = '0;
                    end else begin
                        n_lv = i_left;
                    end
                end
            end
            CC_ADD: begin
                if (o_match) begin
                    n_lv.total = r_lv.total + i_ctl.delta;
                    n_lv.count = r_lv.count + {{(COUNT_W-1){1'b0}}, i_ctl.dec};
                end
            end
            CC_SUB: begin
                if (o_match) begin
                    n_lv.total = r_lv.total - i_ctl.delta;
                    n_lv.count = r_lv.count - {{(COUNT_W-1){1'b0}}, i_ctl.dec};
                end
            end
            CC_REMOVE: begin
                if (!o_better) n_lv = i_right;
            end
            default: n_lv = r_lv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lv <= n_lv;
    end

    assign o_level = r_lv;
endmodule
`default_nettype wire

// ----- sv/plob_side.sv -----
// ---------------------------------------------------------------------------
// plob_side
// Row of level cells for one side, with its used count and level read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module plob_side #(
    parameter int LEVELS = plob_pkg::LEVELS_DEF,
    parameter int LVL_W  = $clog2(LEVELS)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_sell,
    input  plob_pkg::t_cell_ctl   i_ctl,
    input  wire [LVL_W-1:0]       i_rd_idx,
    output plob_pkg::t_level      o_rd_level,
    output logic [LVL_W:0]        o_used,
    output logic                  o_found,
    output logic                  o_zero_after_sub
);
    import plob_pkg::*;

    t_level           w_lv    [LEVELS];
    logic [LEVELS-1:0] w_match;
    logic [LEVELS-1:0] w_better;
    logic [LVL_W:0]   r_used;
    logic [LVL_W:0]   n_used;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_cell
            t_level w_l;
            t_level w_r;
            logic   w_lb;
            if (g == 0) begin : g_first
                assign w_l  = '0;
                assign w_lb = 1'b1;
            end else begin : g_mid
                assign w_l  = w_lv[g-1];
                assign w_lb = w_better[g-1];
            end
            if (g == LEVELS-1) begin : g_last
                assign w_r = '0;
            end else begin : g_inner
                assign w_r = w_lv[g+1];
            end
            plob_cell u_cell (
                .i_clk         (i_clk),
                .i_sell        (i_sell),
                .i_here_used   ((LVL_W+1)'(g) < r_used),
                .i_ctl         (i_ctl),
                .i_left        (w_l),
                .i_left_better (w_lb),
                .i_right       (w_r),
                .o_level       (w_lv[g]),
                .o_match       (w_match[g]),
                .o_better      (w_better[g])
            );
        end
    endgenerate

    // flag that the matching level's count reaches zero after a subtract of one order
    always_comb begin
        o_zero_after_sub = 1'b0;
        for (int k = 0; k < LEVELS; k++)
            if (w_match[k] && w_lv[k].count == COUNT_W'(1)) o_zero_after_sub = 1'b1;
    end

    assign o_found    = |w_match;
    assign o_rd_level = w_lv[i_rd_idx];
    assign o_used     = r_used;

    // track the used count
    always_comb begin
        n_used = r_used;
        if (i_ctl.cmd == CC_INSERT)      n_used = r_used + 1'b1;
        else if (i_ctl.cmd == CC_REMOVE) n_used = r_used - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_used <= '0;
        else          r_used <= n_used;
    end
endmodule
`default_nettype wire

// ----- sv/price_level_order_book.sv -----
// Steps from accepted word to result word: fetch, execute and output, with an add
// step for new or replace, an insert step to open a level and a remove step to close one.
// The input stalls until the result word is loaded into the output register, so a new
// word is not taken before the last one is through.
// Reset: synchronous, active low; used level counts clear, then a clearing pass over
// all ORDER_SLOTS records (1024 by default) clears the record valid marks.
`timescale 1ns / 1ps
`default_nettype none
`include "price_level_order_book_macros.svh"
// ---------------------------------------------------------------------------
// price_level_order_book
// Order records plus two rows of price level cells, driven by a sequencer.
// ---------------------------------------------------------------------------
module price_level_order_book #(
    parameter int ORDER_SLOTS     = plob_pkg::ORDER_SLOTS_DEF,
    parameter int LEVELS_PER_SIDE = plob_pkg::LEVELS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire [2:0]                  i_operation,
    input  wire                        i_is_sell,
    input  wire [plob_pkg::ID_W-1:0]   i_order_ident,
    input  wire [plob_pkg::ID_W-1:0]   i_previous_ident,
    input  wire [plob_pkg::QTY_W-1:0]  i_quantity,
    input  wire [plob_pkg::PRICE_W-1:0] i_price_ticks,
    input  wire [plob_pkg::IDX_W-1:0]  i_level_index,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [plob_pkg::TOTAL_W-1:0] o_answer,
    output logic [2:0]                 o_status
);
    import plob_pkg::*;

    localparam int LVL_W  = $clog2(LEVELS_PER_SIDE);
    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam int REC_W  = 2 + QTY_W + PRICE_W;

    // captured command
    t_op                r_op;
    logic               r_sell;
    logic [ID_W-1:0]    r_id, r_prev;
    logic [QTY_W-1:0]   r_qty;
    logic [PRICE_W-1:0] r_price;
    logic [IDX_W-1:0]   r_idx;
    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_clr;
    logic [REC_W-1:0]   r_mem [ORDER_SLOTS];
    logic [REC_W-1:0]   r_rec_id, r_rec_prev;
    logic               r_out_v;
    logic [TOTAL_W-1:0] r_ans;
    t_status            r_st;
    logic [TOTAL_W-1:0] r_wans;
    t_status            r_wst;
    logic               r_rm_sell;
    logic [PRICE_W-1:0] r_rm_price;

    // record fields
    logic               rec_live, rprev_live;
    logic               rec_sell, rprev_sell;
    logic [QTY_W-1:0]   rec_qty, rprev_qty;
    logic [PRICE_W-1:0] rec_price, rprev_price;
    assign {rec_live, rec_sell, rec_qty, rec_price}         = r_rec_id;
    assign {rprev_live, rprev_sell, rprev_qty, rprev_price} = r_rec_prev;

    // id range and liveness
    logic w_id_in, w_prev_in, w_id_live, w_prev_live;
    assign w_id_in     = ({22'b0, r_id}   < 32'(ORDER_SLOTS));
    assign w_prev_in   = ({22'b0, r_prev} < 32'(ORDER_SLOTS));
    assign w_id_live   = w_id_in   && rec_live;
    assign w_prev_live = w_prev_in && rprev_live;

    // side rows
    t_cell_ctl          w_ctl [2];
    t_level             w_rd  [2];
    logic [LVL_W:0]     w_used [2];
    logic [1:0]         w_found, w_zero;

    genvar s;
    generate
        for (s = 0; s < 2; s++) begin : g_side
            plob_side #(.LEVELS(LEVELS_PER_SIDE), .LVL_W(LVL_W)) u_side (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_sell           (s == 1),
                .i_ctl            (w_ctl[s]),
                .i_rd_idx         (LVL_W'(r_idx)),
                .o_rd_level       (w_rd[s]),
                .o_used           (w_used[s]),
                .o_found          (w_found[s]),
                .o_zero_after_sub (w_zero[s])
            );
        end
    endgenerate

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_v;
    assign o_answer = r_ans;
    assign o_status = r_st;

    // sequencer control
    t_cell_ctl          n_ctl0, n_ctl1;
    logic               n_out_v, n_load, n_wr;
    logic [SLOT_W-1:0]  n_wr_addr;
    logic [REC_W-1:0]   n_wr_data;
    logic [TOTAL_W-1:0] n_wans;
    t_status            n_wst;
    logic               n_rm_sell;
    logic [PRICE_W-1:0] n_rm_price;

    always_comb begin
        n_state    = r_state;
        n_ctl0     = '{cmd: CC_NONE, price: r_price, delta: '0, dec: 1'b0};
        n_ctl1     = n_ctl0;
        n_out_v    = r_out_v && i_stall;
        n_load     = 1'b0;
        n_wans     = r_wans;
        n_wst      = r_wst;
        n_rm_sell  = r_rm_sell;
        n_rm_price = r_rm_price;
        n_wr       = 1'b0;
        n_wr_addr  = SLOT_W'(r_id);
        n_wr_data  = {1'b1, r_sell, r_qty, r_price};
        unique case (r_state)
            S_CLEAR: begin
                // wipe one record per cycle after reset
                n_wr      = 1'b1;
                n_wr_addr = r_clr;
                n_wr_data = '0;
                if (r_clr == SLOT_W'(ORDER_SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_FETCH;
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                n_wans  = '0;
                n_wst   = ST_OK;
                n_state = S_OUT;
                case (r_op) inside
                    OP_NEW: begin
                        if (!w_id_in) n_wst = ST_UNKNOWN;
                        else if (w_id_live) n_wst = ST_DUP;
                        else n_state = S_ADD;
                    end
                    OP_CHANGE: begin
                        if (!w_id_live) n_wst = ST_UNKNOWN;
                        else begin
                            // change the total by new minus old size
                            n_ctl0.price = rec_price;
                            n_ctl0.cmd   = CC_ADD;
                            n_ctl0.delta = TOTAL_W'(r_qty) - TOTAL_W'(rec_qty);
                            if (rec_sell) n_ctl1 = n_ctl0;
                            if (rec_sell) n_ctl0.cmd = CC_NONE;
                            n_wr      = 1'b1;
                            n_wr_data = {1'b1, rec_sell, r_qty, rec_price};
                        end
                    end
                    OP_REPL, OP_DEL: begin
                        if ((r_op == OP_REPL) ? !w_prev_live : !w_id_live)
                            n_wst = ST_UNKNOWN;
                        else if (r_op == OP_REPL && w_id_live && r_id != r_prev)
                            n_wst = ST_DUP;
                        else begin
                            n_rm_sell  = (r_op == OP_REPL) ? rprev_sell : rec_sell;
                            n_rm_price = (r_op == OP_REPL) ? rprev_price : rec_price;
                            n_ctl0.price = n_rm_price;
                            n_ctl0.cmd   = CC_SUB;
                            n_ctl0.delta = TOTAL_W'((r_op == OP_REPL) ? rprev_qty : rec_qty);
                            n_ctl0.dec   = 1'b1;
                            if (n_rm_sell) begin
                                n_ctl1 = n_ctl0;
                                n_ctl0.cmd = CC_NONE;
                            end
                            // drop the record
                            n_wr      = 1'b1;
                            n_wr_addr = SLOT_W'((r_op == OP_REPL) ? r_prev : r_id);
                            n_wr_data = '0;
                            // close the level when its last order leaves
                            if (w_found[n_rm_sell] && w_zero[n_rm_sell]) n_state = S_RM;
                            else if (r_op == OP_REPL) n_state = S_ADD;
                        end
                    end
                    OP_QNUM: n_wans = TOTAL_W'(w_used[r_sell]);
                    default: begin
                        if (32'(r_idx) >= 32'(w_used[r_sell])) n_wst = ST_RANGE;
                        else if (r_op == OP_QPRICE) n_wans = TOTAL_W'(w_rd[r_sell].price);
                        else if (r_op == OP_QSIZE)  n_wans = w_rd[r_sell].total;
                        else n_wans = TOTAL_W'(w_rd[r_sell].count);
                    end
                endcase
            end
            S_RM: begin
                // shift the worse levels over the emptied one
                n_ctl0.cmd   = CC_REMOVE;
                n_ctl0.price = r_rm_price;
                if (r_rm_sell) begin
                    n_ctl1 = n_ctl0;
                    n_ctl0.cmd = CC_NONE;
                end
                n_state = (r_op == OP_REPL) ? S_ADD : S_OUT;
            end
            S_ADD: begin
                // insert a level if needed (a bad id or a full side gives an error), then add the order to it
                if (!w_id_in) begin
                    n_wst   = ST_UNKNOWN;
                    n_state = S_OUT;
                end else if (!w_found[r_sell] &&
                             w_used[r_sell] == (LVL_W+1)'(LEVELS_PER_SIDE)) begin
                    n_wst   = ST_FULL;
                    n_state = S_OUT;
                end else if (!w_found[r_sell]) begin
                    n_ctl0.cmd = CC_INSERT;
                end else begin
                    n_ctl0.cmd   = CC_ADD;
                    n_ctl0.delta = TOTAL_W'(r_qty);
                    n_ctl0.dec   = 1'b1;
                    n_wr    = 1'b1;
                    n_state = S_OUT;
                end
                if (r_sell) begin
                    n_ctl1 = n_ctl0;
                    n_ctl0.cmd = CC_NONE;
                end
            end
            S_OUT: begin
                // load the result word once the output register is free
                if (!r_out_v || !i_stall) begin
                    n_out_v = 1'b1;
                    n_load  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_out_v = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        w_ctl[0] = n_ctl0;
        w_ctl[1] = n_ctl1;
    end

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
        end
        r_wans     <= n_wans;
        r_wst      <= n_wst;
        r_rm_sell  <= n_rm_sell;
        r_rm_price <= n_rm_price;
        if (n_load) begin
            r_ans <= r_wans;
            r_st  <= r_wst;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_op    <= t_op'(i_operation);
            r_sell  <= i_is_sell;
            r_id    <= i_order_ident;
            r_prev  <= i_previous_ident;
            r_qty   <= i_quantity;
            r_price <= i_price_ticks;
            r_idx   <= i_level_index;
        end
    end

    // order record memory
    always_ff @(posedge i_clk) begin
        if (n_wr) r_mem[n_wr_addr] <= n_wr_data;
        r_rec_id   <= r_mem[SLOT_W'(r_id)];
        r_rec_prev <= r_mem[SLOT_W'(r_prev)];
    end

    `PLOB_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `PLOB_ASSERT_NXT(a_exec_follows_fetch, i_clk, i_rst_n, r_state == S_FETCH,
        r_state == S_EXEC)
    `PLOB_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1,
        w_used[0] <= (LVL_W+1)'(LEVELS_PER_SIDE) && w_used[1] <= (LVL_W+1)'(LEVELS_PER_SIDE))
    `PLOB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_answer) && $stable(o_status))
endmodule
`default_nettype wire
